>>> src/msw_pkg.sv
// Package for the multiplexed stream state and window unit.
// Holds widths, codes, item and result types shared by all files.
// No dependencies.
package msw_pkg;

    localparam int WIN_W       = 25;   // window, receive credit and byte count width
    localparam int CFG_W       = 25;   // widest configuration register
    localparam int CREDIT_W    = 32;   // send credit width
    localparam int CFG_ADDR_W  = 1;
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 64;

    localparam logic [CFG_W-1:0] MAX_WINDOW_RST = CFG_W'(262144);

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_WINDOW     = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OPENED_BY_PEER = 1'b1;

    // frame flag bits and masks
    localparam int FLAG_SYN_BIT = 0;
    localparam int FLAG_ACK_BIT = 1;
    localparam int FLAG_FIN_BIT = 2;
    localparam int FLAG_RST_BIT = 3;
    localparam logic [3:0] FLAG_NONE = 4'b0000;
    localparam logic [3:0] FLAG_SYN  = 4'b0001;
    localparam logic [3:0] FLAG_ACK  = 4'b0010;
    localparam logic [3:0] FLAG_FIN  = 4'b0100;

    // frame types
    localparam logic FRAME_DATA   = 1'b0;
    localparam logic FRAME_WINUPD = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT        = 3'd0,
        ST_SYN_SENT    = 3'd1,
        ST_SYN_RECV    = 3'd2,
        ST_ESTABLISHED = 3'd3,
        ST_LCLOSE      = 3'd4,
        ST_RCLOSE      = 3'd5,
        ST_CLOSED      = 3'd6,
        ST_RESET       = 3'd7
    } t_state;

    typedef enum logic [2:0] {
        ACT_START       = 3'd0,
        ACT_SEND        = 3'd1,
        ACT_CLOSE       = 3'd2,
        ACT_FORCE_CLOSE = 3'd3,
        ACT_RX_DATA     = 3'd4,
        ACT_RX_WINUPD   = 3'd5,
        ACT_APP_READ    = 3'd6,
        ACT_OFFER_UPD   = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_BLOCK = 2'd1,
        STS_ERROR = 2'd2,
        STS_EOS   = 2'd3
    } t_status;

    typedef struct packed {
        t_action          action;
        logic [3:0]       rx_flags;
        logic [WIN_W-1:0] byte_count;
    } t_item;

    typedef struct packed {
        t_status          status;
        logic             frame_out;
        logic             frame_type;
        logic [3:0]       frame_flags;
        logic [WIN_W-1:0] frame_length;
        logic [WIN_W-1:0] read_bytes;
        logic             close_notify;
        logic             data_notify;
        t_state           state_now;
    } t_result;

endpackage

>>> src/msw_engine.sv
// Stream state machine and credit registers; computes one result per item.
// Depends on msw_pkg.
module msw_engine import msw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  t_item            i_item,
    input  logic [CFG_W-1:0] i_max_window,
    input  logic             i_opened_by_peer,
    output t_result          o_result
);

    t_state              r_state,       n_state;
    logic [CREDIT_W-1:0] r_send_credit, n_send_credit;
    logic [WIN_W-1:0]    r_recv_credit, n_recv_credit;
    logic [WIN_W-1:0]    r_buffered,    n_buffered;

    // shared decode
    logic                shut;
    logic [3:0]          ff_flags;
    t_state              ff_state;
    t_state              tf_state;
    logic                tf_ok;
    logic                tf_closing;
    logic                send_zero;
    logic [CREDIT_W-1:0] n_ext;
    logic [CREDIT_W-1:0] send_rem;
    logic [CREDIT_W:0]   credit_sum;
    logic [CREDIT_W-1:0] credit_sat;
    logic                rx_fits;
    logic [WIN_W:0]      buf_sum;
    logic [WIN_W-1:0]    buf_sat;
    logic [WIN_W-1:0]    rd_len;
    logic [WIN_W-1:0]    win;
    logic [WIN_W:0]      used;
    logic [WIN_W:0]      delta_full;
    logic [WIN_W-1:0]    delta;
    logic                offer_send;
    logic                close_frame;

    assign shut       = (r_state >= ST_LCLOSE);
    assign win        = WIN_W'(i_max_window);
    assign send_zero  = (r_send_credit == '0);
    assign n_ext      = CREDIT_W'(i_item.byte_count);
    assign send_rem   = (r_send_credit > n_ext) ? (r_send_credit - n_ext) : '0;
    assign credit_sum = {1'b0, r_send_credit} + {1'b0, n_ext};
    assign credit_sat = credit_sum[CREDIT_W] ? '1 : credit_sum[CREDIT_W-1:0];
    assign rx_fits    = (i_item.byte_count <= r_recv_credit);
    assign buf_sum    = {1'b0, r_buffered} + {1'b0, i_item.byte_count};
    assign buf_sat    = buf_sum[WIN_W] ? '1 : buf_sum[WIN_W-1:0];
    assign rd_len     = (i_item.byte_count < r_buffered) ? i_item.byte_count : r_buffered;
    assign used       = {1'b0, r_buffered} + {1'b0, r_recv_credit};
    assign delta_full = ({1'b0, win} > used) ? ({1'b0, win} - used) : '0;
    assign delta      = delta_full[WIN_W-1:0];
    assign offer_send = !((delta < (win >> 1)) && (ff_flags == FLAG_NONE));
    assign close_frame = (r_state == ST_SYN_SENT) || (r_state == ST_SYN_RECV) ||
                         (r_state == ST_ESTABLISHED);

    // flags due on the first frame, and the state that follows
    always_comb begin
        ff_flags = FLAG_NONE;
        ff_state = r_state;
        if (r_state == ST_INIT) begin
            ff_flags = FLAG_SYN;
            ff_state = ST_SYN_SENT;
        end else if (r_state == ST_SYN_RECV) begin
            ff_flags = FLAG_ACK;
            ff_state = ST_ESTABLISHED;
        end
    end

    // received flags: ACK, then FIN, then RST; illegal FIN leaves state alone
    always_comb begin
        tf_state   = r_state;
        tf_ok      = 1'b1;
        tf_closing = 1'b0;
        if (i_item.rx_flags[FLAG_ACK_BIT] && (r_state == ST_SYN_SENT)) begin
            tf_state = ST_ESTABLISHED;
        end
        if (i_item.rx_flags[FLAG_FIN_BIT]) begin
            if ((tf_state == ST_SYN_SENT) || (tf_state == ST_SYN_RECV) ||
                (tf_state == ST_ESTABLISHED)) begin
                tf_state   = ST_RCLOSE;
                tf_closing = 1'b1;
            end else if (tf_state == ST_LCLOSE) begin
                tf_closing = 1'b1;
            end else begin
                tf_ok    = 1'b0;
                tf_state = r_state;
            end
        end
        if (i_item.rx_flags[FLAG_RST_BIT] && tf_ok) begin
            tf_state   = ST_RESET;
            tf_closing = 1'b1;
        end
    end

    // next state and credits
    always_comb begin
        n_state       = r_state;
        n_send_credit = r_send_credit;
        n_recv_credit = r_recv_credit;
        n_buffered    = r_buffered;
        unique case (i_item.action)
            ACT_START: begin
                n_state       = i_opened_by_peer ? ST_SYN_RECV : ST_INIT;
                n_send_credit = CREDIT_W'(i_max_window);
                n_recv_credit = win;
                n_buffered    = '0;
            end
            ACT_SEND: begin
                if (!shut && !send_zero) begin
                    n_state       = ff_state;
                    n_send_credit = send_rem;
                end
            end
            ACT_CLOSE: begin
                if (close_frame || (r_state == ST_LCLOSE) || (r_state == ST_RCLOSE)) begin
                    n_state = ST_CLOSED;
                end
            end
            ACT_FORCE_CLOSE: begin
                n_state = ST_CLOSED;
            end
            ACT_RX_DATA: begin
                if (tf_ok) begin
                    n_state = tf_state;
                    if (rx_fits) begin
                        n_recv_credit = r_recv_credit - i_item.byte_count;
                        n_buffered    = buf_sat;
                    end
                end
            end
            ACT_RX_WINUPD: begin
                if (tf_ok) begin
                    n_state       = tf_state;
                    n_send_credit = credit_sat;
                end
            end
            ACT_APP_READ: begin
                n_buffered = r_buffered - rd_len;
            end
            ACT_OFFER_UPD: begin
                n_state = ff_state;
                if (offer_send) begin
                    n_recv_credit = r_recv_credit + delta;
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    // result fields
    always_comb begin
        o_result           = '0;
        o_result.status    = STS_OK;
        o_result.state_now = n_state;
        unique case (i_item.action)
            ACT_SEND: begin
                if (shut) begin
                    o_result.status = STS_ERROR;
                end else if (send_zero) begin
                    o_result.status = STS_BLOCK;
                end else begin
                    o_result.frame_out    = 1'b1;
                    o_result.frame_type   = FRAME_DATA;
                    o_result.frame_flags  = ff_flags;
                    o_result.frame_length = i_item.byte_count;
                end
            end
            ACT_CLOSE: begin
                if (r_state == ST_INIT) begin
                    o_result.status = STS_ERROR;
                end else if (close_frame) begin
                    o_result.frame_out   = 1'b1;
                    o_result.frame_type  = FRAME_WINUPD;
                    o_result.frame_flags = ff_flags | FLAG_FIN;
                end
            end
            ACT_FORCE_CLOSE: begin
                o_result.close_notify = 1'b1;
            end
            ACT_RX_DATA: begin
                if (!tf_ok || !rx_fits) begin
                    o_result.status = STS_ERROR;
                end else begin
                    o_result.close_notify = tf_closing;
                    o_result.data_notify  = (i_item.byte_count != '0);
                end
            end
            ACT_RX_WINUPD: begin
                if (!tf_ok) begin
                    o_result.status = STS_ERROR;
                end else begin
                    o_result.close_notify = tf_closing;
                end
            end
            ACT_APP_READ: begin
                if (r_buffered == '0) begin
                    o_result.status = shut ? STS_EOS : STS_BLOCK;
                end else begin
                    o_result.read_bytes = rd_len;
                end
            end
            ACT_OFFER_UPD: begin
                if (offer_send) begin
                    o_result.frame_out    = 1'b1;
                    o_result.frame_type   = FRAME_WINUPD;
                    o_result.frame_flags  = ff_flags;
                    o_result.frame_length = delta;
                end
            end
            default: begin
                o_result.status = STS_OK;  // start: nothing but the state
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_INIT;
            r_send_credit <= '0;
            r_recv_credit <= '0;
            r_buffered    <= '0;
        end else if (i_take) begin
            r_state       <= n_state;
            r_send_credit <= n_send_credit;
            r_recv_credit <= n_recv_credit;
            r_buffered    <= n_buffered;
        end
    end

endmodule

>>> src/mux_stream_state_and_window_unit.sv
// Top level of the multiplexed stream state and window unit.
// Holds configuration registers and the two-entry result buffer.
// Depends on msw_pkg and msw_engine.

// One endpoint of a multiplexed stream: state machine (SYN/ACK/FIN/RST),
// send credit (32 bits, saturating), receive credit and a buffered byte
// count. Every accepted input transaction produces exactly one result
// transaction. An item is evaluated in the cycle it is accepted against the
// state registers, which update at that edge, so the unit takes one item per
// clock while s_axis_tready is high; the result is registered and appears on
// the master side in the cycle after acceptance when the output register is
// free. Results wait in a result register plus one skid entry, so input keeps
// flowing while a single result is stalled; s_axis_tready drops only when both
// entries hold results. Configuration (max_window, opened_by_peer) is written
// through the plain write port and should only change while no result is
// pending; a start action loads both credits from max_window.
module mux_stream_state_and_window_unit import msw_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side: tuser = action[2:0]
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // tdata: rx_flags[3:0], byte_count[28:4], zero pad [31:29]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    // master side
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // tdata: status[1:0], frame_out[2], frame_flags[6:3], frame_length[31:7],
    //        read_bytes[56:32], close_notify[57], data_notify[58],
    //        state_now[61:59], zero pad [63:62]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // tuser: frame_type
    output logic                   o_m_axis_tuser,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    logic [CFG_W-1:0] r_max_window;
    logic             r_opened_by_peer;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    t_item   item;
    t_result result;
    logic    take;
    logic    pop;

    assign item.action     = t_action'(i_s_axis_tuser);
    assign item.rx_flags   = i_s_axis_tdata[3:0];
    assign item.byte_count = i_s_axis_tdata[WIN_W+3:4];

    // ready comes from a register: skid entry free
    assign o_s_axis_tready = !r_skid_valid;
    assign take            = i_s_axis_tvalid && o_s_axis_tready;
    assign pop             = r_out_valid && i_m_axis_tready;

    msw_engine u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_take           (take),
        .i_item           (item),
        .i_max_window     (r_max_window),
        .i_opened_by_peer (r_opened_by_peer),
        .o_result         (result)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_window     <= MAX_WINDOW_RST;
            r_opened_by_peer <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MAX_WINDOW:     r_max_window     <= i_cfg_wdata;
                CFG_OPENED_BY_PEER: r_opened_by_peer <= i_cfg_wdata[0];
                default:            r_max_window     <= r_max_window;
            endcase
        end
    end

    // result buffer control; a take only happens with the skid entry empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (take) begin
                if (r_out_valid && !pop) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (pop) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    // result buffer payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_out_valid && !pop) begin
                r_skid <= result;
            end else begin
                r_out <= result;
            end
        end else if (pop && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.frame_type;
    assign o_m_axis_tdata  = {2'b00, r_out.state_now, r_out.data_notify,
                              r_out.close_notify, r_out.read_bytes,
                              r_out.frame_length, r_out.frame_flags,
                              r_out.frame_out, r_out.status};

endmodule

>>> src/msw_checker.sv
// Port-level checks for the multiplexed stream state and window unit.
// Depends on msw_pkg; bound to mux_stream_state_and_window_unit below.
module msw_checker import msw_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                   o_m_axis_tuser
);

    // reset leaves the buffer empty and ready
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_s_axis_tready && !o_m_axis_tvalid))
        else $error("buffer not empty after reset");

    // back-pressure only when a result is on display
    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with no result pending");

    // a transaction into an empty output shows up next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && !o_m_axis_tvalid) |=> o_m_axis_tvalid)
        else $error("result missing after accepted transaction");

    // no frame means clean frame fields, and errors never carry a frame
    a_no_frame_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (!o_m_axis_tdata[2] ||
            (o_m_axis_tdata[1:0] == STS_ERROR))) |->
        (!o_m_axis_tdata[2] && !o_m_axis_tuser && (o_m_axis_tdata[31:3] == '0)))
        else $error("frame fields set without a frame");

    // stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind mux_stream_state_and_window_unit msw_checker u_msw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
